[rtl/cdg_pkg.sv]
// ----------------------------------------------------------------------------
// CD+G renderer package
// Shared geometry, codes and types of the CD+G packet renderer.
// ----------------------------------------------------------------------------
package cdg_pkg;

    localparam int unsigned SCR_W      = 300;
    localparam int unsigned SCR_H      = 216;
    localparam int unsigned TILE_W     = 6;
    localparam int unsigned TILE_H     = 12;
    localparam int unsigned TILE_COLS  = SCR_W / TILE_W;
    localparam int unsigned TILE_ROWS  = SCR_H / TILE_H;
    localparam int unsigned WPR        = TILE_COLS;
    localparam int unsigned WORD_COUNT = WPR * SCR_H;
    localparam int unsigned ROW_BAND   = WPR * TILE_H;
    localparam int unsigned PIX_W      = 4;
    localparam int unsigned WORD_W     = PIX_W * TILE_W;
    localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [PIX_W-1:0]  nib_t;

    localparam logic [1:0] FUNC_APPLY   = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [5:0] CMD_GRAPHICS      = 6'h09;
    localparam logic [5:0] INS_MEM_PRESET    = 6'd1;
    localparam logic [5:0] INS_BORDER        = 6'd2;
    localparam logic [5:0] INS_TILE          = 6'd6;
    localparam logic [5:0] INS_TILE_XOR      = 6'd38;
    localparam logic [5:0] INS_SCROLL_PRESET = 6'd20;
    localparam logic [5:0] INS_SCROLL_COPY   = 6'd24;
    localparam logic [5:0] INS_TRANSPARENT   = 6'd28;
    localparam logic [5:0] INS_PAL_LOW       = 6'd30;
    localparam logic [5:0] INS_PAL_HIGH      = 6'd31;

    localparam logic [1:0] SCR_FWD  = 2'd1;
    localparam logic [1:0] SCR_BACK = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_TILE_RD,
        ST_TILE_WR,
        ST_SC_COPY,
        ST_SC_MOVE,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    typedef enum logic [1:0] {
        LOP_COPY,
        LOP_FILL,
        LOP_TILE,
        LOP_TILE_XOR
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        nib_t     c0;
        nib_t     c1;
    } lane_ctrl_t;

    // Word address of the first word of a pixel row (row times 50).
    function automatic addr_t row_base(input logic [7:0] y);
        return addr_t'({y, 5'b0}) + addr_t'({y, 4'b0}) + addr_t'({y, 1'b0});
    endfunction

endpackage

[rtl/cdg_lane.sv]
// ----------------------------------------------------------------------------
// CD+G pixel lane
// Computes the new colour index of one pixel of a six-pixel word.
// ----------------------------------------------------------------------------
module cdg_lane (
    input  cdg_pkg::lane_ctrl_t ctrl,
    input  cdg_pkg::nib_t       old_pix,
    input  logic                tile_bit,
    output cdg_pkg::nib_t       new_pix
);
    import cdg_pkg::*;

    nib_t tile_col;

    assign tile_col = tile_bit ? ctrl.c1 : ctrl.c0;

    always_comb begin
        unique case (ctrl.op)
            LOP_COPY:     new_pix = old_pix;
            LOP_FILL:     new_pix = ctrl.c0;
            LOP_TILE:     new_pix = tile_col;
            LOP_TILE_XOR: new_pix = old_pix ^ tile_col;
            default:      new_pix = old_pix;
        endcase
    end

endmodule

[rtl/cdg_ram.sv]
// ----------------------------------------------------------------------------
// CD+G word memory
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module cdg_ram #(
    parameter int unsigned DEPTH  = 10800,
    parameter int unsigned WIDTH  = 24,
    parameter int unsigned ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/cd_graphics_packet_renderer_core.sv]
// ----------------------------------------------------------------------------
// CD+G packet renderer core
// Draws CD+G subcode graphics packets into a 300x216 frame and reads pixels.
// ----------------------------------------------------------------------------
// The frame is held as 216 rows of 50 words, each word carrying six 4-bit
// colour indices, so one tile row, one border column and one horizontal
// scroll step are all exactly one word. Six pixel lanes work side by side
// on the pixels of a word and their results are merged into the word that
// is written back. One transaction is handled at a time. A pixel read
// passes through an issue state and a data state before its result reaches
// the result register, and the next transaction can be accepted once the
// block is back in idle; a read waits in the data state only while an
// earlier result still sits in the output register. Palette loads, define
// transparent and ignored packets are finished in idle. A tile does a read
// and a write for each of its twelve rows. Memory preset, taken only when
// the low nibble of its second byte is zero, and border preset sweep all
// 10800 words, one a cycle; border preset writes only the border words. A
// scroll that moves first copies the frame to a snapshot memory and then
// rebuilds it from that snapshot. After reset, and after a restart
// transaction, a clearing pass writes the frame to zero; no transaction is
// accepted until it ends. A pending result may wait in the output register
// while the next transaction is accepted.
// ----------------------------------------------------------------------------
module cd_graphics_packet_renderer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [5:0]  s_command_code,
    input  logic [5:0]  s_instruction_code,
    input  logic [63:0] s_payload_low,
    input  logic [63:0] s_payload_high,
    input  logic [8:0]  s_pixel_x,
    input  logic [7:0]  s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_argb,
    output logic [3:0]  m_color_index,
    output logic        m_pixel_transparent,
    output logic [2:0]  m_h_offset,
    output logic [3:0]  m_v_offset
);
    import cdg_pkg::*;

    // Control and working registers.
    state_t      state_reg, state_next;
    addr_t       addr_reg, addr_next;
    logic [7:0]  y_reg, y_next;
    logic [5:0]  w_reg, w_next;
    logic        iss_done_reg, iss_done_next;
    logic        pv_reg, pv_next;
    addr_t       pdst_reg, pdst_next;
    logic        pfill_reg, pfill_next;
    nib_t        sweep_col_reg, sweep_col_next;
    logic        sweep_ring_reg, sweep_ring_next;
    addr_t       tile_addr_reg, tile_addr_next;
    logic [3:0]  tile_row_reg, tile_row_next;
    logic [95:0] tile_bits_reg, tile_bits_next;
    nib_t        tile_c0_reg, tile_c0_next;
    nib_t        tile_c1_reg, tile_c1_next;
    logic        tile_xor_reg, tile_xor_next;
    logic [1:0]  sc_h_reg, sc_h_next;
    logic [1:0]  sc_v_reg, sc_v_next;
    logic        sc_wrap_reg, sc_wrap_next;
    nib_t        sc_fill_reg, sc_fill_next;
    logic [8:0]  rd_x_reg, rd_x_next;
    logic [7:0]  rd_y_reg, rd_y_next;
    logic [2:0]  rd_lane_reg, rd_lane_next;
    logic [11:0] pal_reg [16];
    logic [11:0] pal_next [16];
    logic        tr_valid_reg, tr_valid_next;
    nib_t        tr_idx_reg, tr_idx_next;
    nib_t        border_reg, border_next;
    logic [2:0]  hoff_reg, hoff_next;
    logic [3:0]  voff_reg, voff_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_argb_reg, m_argb_next;
    nib_t        m_idx_reg, m_idx_next;
    logic        m_tr_reg, m_tr_next;
    logic [2:0]  m_hoff_reg, m_hoff_next;
    logic [3:0]  m_voff_reg, m_voff_next;

    // Memory ports.
    logic  frame_we, frame_re, snap_we, snap_re;
    addr_t frame_waddr, frame_raddr, snap_raddr;
    word_t frame_rdata, snap_rdata, lane_word, lane_old;
    lane_ctrl_t lane_ctrl;
    logic [5:0] lane_bits;

    // Decoded views of the incoming transaction.
    logic [127:0] pay;
    logic [7:0]   byte0, byte1, byte2, byte3;
    logic         accept;
    logic         move;
    addr_t        tile_base;

    // Sweep and scroll geometry.
    logic         last_word;
    logic         ring;
    logic signed [9:0] sy;
    logic signed [7:0] sw;
    logic         src_out;
    addr_t        src_addr;

    // Pixel read helpers.
    logic [16:0]  q_prod;
    logic [5:0]   q_word;
    logic [8:0]   q_times6;
    nib_t         rd_pix;
    logic [11:0]  rd_col;
    logic         rd_tr;

    assign pay    = {s_payload_high, s_payload_low};
    assign byte0  = pay[7:0];
    assign byte1  = pay[15:8];
    assign byte2  = pay[23:16];
    assign byte3  = pay[31:24];
    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign move = (byte1[5:4] == SCR_FWD) || (byte1[5:4] == SCR_BACK) ||
                  (byte2[5:4] == SCR_FWD) || (byte2[5:4] == SCR_BACK);
    assign tile_base = addr_t'(byte2[4:0]) * addr_t'(ROW_BAND) + addr_t'(byte3[5:0]);

    assign last_word = (addr_reg == addr_t'(WORD_COUNT - 1));
    assign ring = (y_reg < 8'(TILE_H)) || (y_reg >= 8'(SCR_H - TILE_H)) ||
                  (w_reg == 6'd0) || (w_reg == 6'(WPR - 1));

    // Source word of a scroll: a vertical step is one tile height of rows,
    // a horizontal step is exactly one word.
    always_comb begin
        sy = $signed({2'b00, y_reg});
        sw = $signed({2'b00, w_reg});
        if (sc_v_reg == SCR_FWD) begin
            sy = sy - 10'sd12;
        end else if (sc_v_reg == SCR_BACK) begin
            sy = sy + 10'sd12;
        end
        if (sc_h_reg == SCR_FWD) begin
            sw = sw - 8'sd1;
        end else if (sc_h_reg == SCR_BACK) begin
            sw = sw + 8'sd1;
        end
        if (sc_wrap_reg) begin
            if (sy < 10'sd0) begin
                sy = sy + 10'sd216;
            end else if (sy >= 10'sd216) begin
                sy = sy - 10'sd216;
            end
            if (sw < 8'sd0) begin
                sw = sw + 8'sd50;
            end else if (sw >= 8'sd50) begin
                sw = sw - 8'sd50;
            end
        end
        src_out  = (sy < 10'sd0) || (sy >= 10'sd216) || (sw < 8'sd0) || (sw >= 8'sd50);
        src_addr = row_base(sy[7:0]) + addr_t'(sw[5:0]);
    end

    // Column to word and lane: x / 6 through a reciprocal, exact for x < 300.
    assign q_prod   = 17'(rd_x_reg) * 17'd171;
    assign q_word   = q_prod[15:10];
    assign q_times6 = {1'b0, q_word, 2'b00} + {2'b00, q_word, 1'b0};

    // Pixel selection, palette lookup and transparency of a read.
    assign rd_pix = frame_rdata[{rd_lane_reg, 2'b00} +: PIX_W];
    assign rd_col = pal_reg[rd_pix];
    assign rd_tr  = (tr_valid_reg && (rd_pix == tr_idx_reg)) || (rd_pix == border_reg);

    // Lane control: what each of the six pixel lanes does this cycle.
    always_comb begin
        lane_ctrl = '{op: LOP_COPY, c0: '0, c1: '0};
        lane_old  = frame_rdata;
        lane_bits = tile_bits_reg[5:0];
        unique case (state_reg)
            ST_SWEEP: begin
                lane_ctrl = '{op: LOP_FILL, c0: sweep_col_reg, c1: '0};
            end
            ST_TILE_WR: begin
                lane_ctrl = '{op: (tile_xor_reg ? LOP_TILE_XOR : LOP_TILE),
                              c0: tile_c0_reg, c1: tile_c1_reg};
            end
            ST_SC_MOVE: begin
                lane_old  = snap_rdata;
                lane_ctrl = '{op: (pfill_reg ? LOP_FILL : LOP_COPY),
                              c0: sc_fill_reg, c1: '0};
            end
            default: begin
                lane_ctrl = '{op: LOP_COPY, c0: '0, c1: '0};
            end
        endcase
    end

    // Lane 0 is the leftmost pixel; it takes the highest tile bit.
    for (genvar i = 0; i < TILE_W; i++) begin : g_lane
        cdg_lane u_lane (
            .ctrl     (lane_ctrl),
            .old_pix  (lane_old[i*PIX_W +: PIX_W]),
            .tile_bit (lane_bits[TILE_W-1-i]),
            .new_pix  (lane_word[i*PIX_W +: PIX_W])
        );
    end

    // Memory port selection.
    always_comb begin
        frame_we    = 1'b0;
        frame_waddr = addr_reg;
        frame_re    = 1'b0;
        frame_raddr = addr_reg;
        snap_we     = 1'b0;
        snap_re     = 1'b0;
        snap_raddr  = src_addr;
        unique case (state_reg)
            ST_SWEEP: begin
                frame_we = !sweep_ring_reg || ring;
            end
            ST_TILE_RD: begin
                frame_re    = 1'b1;
                frame_raddr = tile_addr_reg;
            end
            ST_TILE_WR: begin
                frame_we    = 1'b1;
                frame_waddr = tile_addr_reg;
            end
            ST_SC_COPY: begin
                frame_re = !iss_done_reg;
                snap_we  = pv_reg;
            end
            ST_SC_MOVE: begin
                snap_re     = !iss_done_reg;
                frame_we    = pv_reg;
                frame_waddr = pdst_reg;
            end
            ST_RD_ISSUE: begin
                frame_re    = 1'b1;
                frame_raddr = row_base(rd_y_reg) + addr_t'(q_word);
            end
            default: begin
                frame_we = 1'b0;
            end
        endcase
    end

    cdg_ram #(
        .DEPTH  (WORD_COUNT),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_frame (
        .aclk  (aclk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (lane_word),
        .re    (frame_re),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    // The snapshot keeps the frame as it was before a scroll.
    cdg_ram #(
        .DEPTH  (WORD_COUNT),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_snap (
        .aclk  (aclk),
        .we    (snap_we),
        .waddr (pdst_reg),
        .wdata (lane_word),
        .re    (snap_re),
        .raddr (snap_raddr),
        .rdata (snap_rdata)
    );

    // Next state and datapath updates.
    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        y_next          = y_reg;
        w_next          = w_reg;
        iss_done_next   = iss_done_reg;
        pv_next         = 1'b0;
        pdst_next       = pdst_reg;
        pfill_next      = pfill_reg;
        sweep_col_next  = sweep_col_reg;
        sweep_ring_next = sweep_ring_reg;
        tile_addr_next  = tile_addr_reg;
        tile_row_next   = tile_row_reg;
        tile_bits_next  = tile_bits_reg;
        tile_c0_next    = tile_c0_reg;
        tile_c1_next    = tile_c1_reg;
        tile_xor_next   = tile_xor_reg;
        sc_h_next       = sc_h_reg;
        sc_v_next       = sc_v_reg;
        sc_wrap_next    = sc_wrap_reg;
        sc_fill_next    = sc_fill_reg;
        rd_x_next       = rd_x_reg;
        rd_y_next       = rd_y_reg;
        rd_lane_next    = rd_lane_reg;
        pal_next        = pal_reg;
        tr_valid_next   = tr_valid_reg;
        tr_idx_next     = tr_idx_reg;
        border_next     = border_reg;
        hoff_next       = hoff_reg;
        voff_next       = voff_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_argb_next     = m_argb_reg;
        m_idx_next      = m_idx_reg;
        m_tr_next       = m_tr_reg;
        m_hoff_next     = m_hoff_reg;
        m_voff_next     = m_voff_reg;

        unique case (state_reg)
            ST_IDLE: begin
                addr_next     = '0;
                y_next        = '0;
                w_next        = '0;
                iss_done_next = 1'b0;
                if (accept) begin
                    priority if (s_func == FUNC_READ) begin
                        rd_x_next  = (s_pixel_x > 9'(SCR_W - 1)) ? 9'(SCR_W - 1) : s_pixel_x;
                        rd_y_next  = (s_pixel_y > 8'(SCR_H - 1)) ? 8'(SCR_H - 1) : s_pixel_y;
                        state_next = ST_RD_ISSUE;
                    end else if (s_func == FUNC_RESTART) begin
                        for (int i = 0; i < 16; i++) begin
                            pal_next[i] = '0;
                        end
                        tr_valid_next   = 1'b0;
                        tr_idx_next     = '0;
                        border_next     = '0;
                        hoff_next       = '0;
                        voff_next       = '0;
                        sweep_col_next  = '0;
                        sweep_ring_next = 1'b0;
                        state_next      = ST_SWEEP;
                    end else if (s_func == FUNC_APPLY &&
                                 s_command_code == CMD_GRAPHICS) begin
                        unique case (s_instruction_code)
                            INS_MEM_PRESET: begin
                                if (byte1[3:0] == 4'd0) begin
                                    border_next     = byte0[3:0];
                                    sweep_col_next  = byte0[3:0];
                                    sweep_ring_next = 1'b0;
                                    state_next      = ST_SWEEP;
                                end
                            end
                            INS_BORDER: begin
                                border_next     = byte0[3:0];
                                sweep_col_next  = byte0[3:0];
                                sweep_ring_next = 1'b1;
                                state_next      = ST_SWEEP;
                            end
                            INS_TILE, INS_TILE_XOR: begin
                                tile_c0_next   = byte0[3:0];
                                tile_c1_next   = byte1[3:0];
                                tile_xor_next  = (s_instruction_code == INS_TILE_XOR);
                                tile_bits_next = pay[127:32];
                                tile_row_next  = '0;
                                tile_addr_next = tile_base;
                                if ((byte2[4:0] < 5'(TILE_ROWS)) &&
                                    (byte3[5:0] < 6'(TILE_COLS))) begin
                                    state_next = ST_TILE_RD;
                                end
                            end
                            INS_SCROLL_PRESET, INS_SCROLL_COPY: begin
                                hoff_next    = (byte1[2:0] > 3'(TILE_W - 1)) ?
                                               3'(TILE_W - 1) : byte1[2:0];
                                voff_next    = (byte2[3:0] > 4'(TILE_H - 1)) ?
                                               4'(TILE_H - 1) : byte2[3:0];
                                sc_h_next    = byte1[5:4];
                                sc_v_next    = byte2[5:4];
                                sc_wrap_next = (s_instruction_code == INS_SCROLL_COPY);
                                sc_fill_next = byte0[3:0];
                                if (move) begin
                                    state_next = ST_SC_COPY;
                                end
                            end
                            INS_TRANSPARENT: begin
                                tr_valid_next = 1'b1;
                                tr_idx_next   = byte0[3:0];
                            end
                            INS_PAL_LOW, INS_PAL_HIGH: begin
                                for (int i = 0; i < 8; i++) begin
                                    pal_next[{(s_instruction_code == INS_PAL_HIGH), 3'(i)}] =
                                        {pay[16*i+2 +: 4], pay[16*i +: 2],
                                         pay[16*i+12 +: 2], pay[16*i+8 +: 4]};
                                end
                            end
                            default: begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SWEEP: begin
                addr_next = addr_reg + addr_t'(1);
                if (w_reg == 6'(WPR - 1)) begin
                    w_next = '0;
                    y_next = y_reg + 8'd1;
                end else begin
                    w_next = w_reg + 6'd1;
                end
                if (last_word) begin
                    state_next = ST_IDLE;
                end
            end

            ST_TILE_RD: begin
                state_next = ST_TILE_WR;
            end

            ST_TILE_WR: begin
                tile_bits_next = {8'd0, tile_bits_reg[95:8]};
                tile_addr_next = tile_addr_reg + addr_t'(WPR);
                tile_row_next  = tile_row_reg + 4'd1;
                state_next     = (tile_row_reg == 4'(TILE_H - 1)) ? ST_IDLE : ST_TILE_RD;
            end

            ST_SC_COPY, ST_SC_MOVE: begin
                if (!iss_done_reg) begin
                    pv_next    = 1'b1;
                    pdst_next  = addr_reg;
                    pfill_next = src_out;
                    addr_next  = addr_reg + addr_t'(1);
                    if (w_reg == 6'(WPR - 1)) begin
                        w_next = '0;
                        y_next = y_reg + 8'd1;
                    end else begin
                        w_next = w_reg + 6'd1;
                    end
                    iss_done_next = last_word;
                end else if (!pv_reg) begin
                    // Last write has landed: move on to the next phase.
                    addr_next     = '0;
                    y_next        = '0;
                    w_next        = '0;
                    iss_done_next = 1'b0;
                    state_next    = (state_reg == ST_SC_COPY) ? ST_SC_MOVE : ST_IDLE;
                end
            end

            ST_RD_ISSUE: begin
                rd_lane_next = 3'(rd_x_reg - q_times6);
                state_next   = ST_RD_DATA;
            end

            ST_RD_DATA: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_argb_next  = {(rd_tr ? 8'h00 : 8'hFF),
                                    {2{rd_col[11:8]}}, {2{rd_col[7:4]}},
                                    {2{rd_col[3:0]}}};
                    m_idx_next   = rd_pix;
                    m_tr_next    = rd_tr;
                    m_hoff_next  = hoff_reg;
                    m_voff_next  = voff_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            addr_reg       <= '0;
            y_reg          <= '0;
            w_reg          <= '0;
            iss_done_reg   <= 1'b0;
            pv_reg         <= 1'b0;
            sweep_col_reg  <= '0;
            sweep_ring_reg <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                pal_reg[i] <= '0;
            end
            tr_valid_reg   <= 1'b0;
            tr_idx_reg     <= '0;
            border_reg     <= '0;
            hoff_reg       <= '0;
            voff_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            y_reg          <= y_next;
            w_reg          <= w_next;
            iss_done_reg   <= iss_done_next;
            pv_reg         <= pv_next;
            sweep_col_reg  <= sweep_col_next;
            sweep_ring_reg <= sweep_ring_next;
            pal_reg        <= pal_next;
            tr_valid_reg   <= tr_valid_next;
            tr_idx_reg     <= tr_idx_next;
            border_reg     <= border_next;
            hoff_reg       <= hoff_next;
            voff_reg       <= voff_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        pdst_reg      <= pdst_next;
        pfill_reg     <= pfill_next;
        tile_addr_reg <= tile_addr_next;
        tile_row_reg  <= tile_row_next;
        tile_bits_reg <= tile_bits_next;
        tile_c0_reg   <= tile_c0_next;
        tile_c1_reg   <= tile_c1_next;
        tile_xor_reg  <= tile_xor_next;
        sc_h_reg      <= sc_h_next;
        sc_v_reg      <= sc_v_next;
        sc_wrap_reg   <= sc_wrap_next;
        sc_fill_reg   <= sc_fill_next;
        rd_x_reg      <= rd_x_next;
        rd_y_reg      <= rd_y_next;
        rd_lane_reg   <= rd_lane_next;
        m_argb_reg    <= m_argb_next;
        m_idx_reg     <= m_idx_next;
        m_tr_reg      <= m_tr_next;
        m_hoff_reg    <= m_hoff_next;
        m_voff_reg    <= m_voff_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_pixel_argb        = m_argb_reg;
    assign m_color_index       = m_idx_reg;
    assign m_pixel_transparent = m_tr_reg;
    assign m_h_offset          = m_hoff_reg;
    assign m_v_offset          = m_voff_reg;

    // The frame is never written while the block waits for a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !frame_we)
        else $error("frame write while idle");

    // The scroll write pipeline is only busy during a scroll.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> (state_reg == ST_SC_COPY || state_reg == ST_SC_MOVE))
        else $error("scroll pipeline active outside a scroll");

    // Sweeps never run past the last word of the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (addr_reg < addr_t'(WORD_COUNT)))
        else $error("sweep address out of range");

endmodule
